// ===== rtl/core/ntc_pkg.sv =====
// ----------------------------------------------------------------------------
// ntc_pkg: shared types and constants of the terrain column generator
// Field widths, register indexes, lattice hash constants and stage counts.
// ----------------------------------------------------------------------------
package ntc_pkg;

	localparam int COL_W      = 12;
	localparam int EXT_W      = 13;
	localparam int HGT_W      = 8;
	localparam int SEED_W     = 32;
	localparam int SPAN_W     = 7;
	localparam int CFG_IDX_W  = 4;
	localparam int CFG_DATA_W = 32;

	// coordinates: 20 fraction bits, scaled by 2^23 / extent
	localparam int CFRAC     = 20;
	localparam int FX_SCALE  = 23;
	localparam int FX_W      = 34;
	localparam int CRD_W     = 36;
	localparam int LAT_IDX_W = CRD_W - CFRAC;

	localparam int COAST_GAIN  = 25;
	localparam int COAST_NUM_W = EXT_W + 5;

	// floor(x / 3) for 8-bit x
	localparam int DIV3_MUL   = 171;
	localparam int DIV3_SHIFT = 9;

	localparam int NOISE_LAT = 6;
	localparam int BLEND_LAT = 8;

	typedef logic [CFG_IDX_W-1:0]  cfg_idx_t;
	typedef logic [CFG_DATA_W-1:0] cfg_data_t;
	typedef logic [COL_W-1:0]      col_t;
	typedef logic [HGT_W-1:0]      hgt_t;

	localparam cfg_idx_t CFG_GRID_EXTENT  = 4'd0;
	localparam cfg_idx_t CFG_HEIGHT_LIMIT = 4'd1;
	localparam cfg_idx_t CFG_NOISE_SEED   = 4'd2;
	localparam cfg_idx_t CFG_LAND_PEAK    = 4'd3;

	localparam logic [EXT_W-1:0]  RST_GRID_EXTENT  = 13'd256;
	localparam logic [HGT_W-1:0]  RST_HEIGHT_LIMIT = 8'd64;
	localparam logic [SEED_W-1:0] RST_NOISE_SEED   = 32'd0;
	localparam logic [HGT_W-1:0]  RST_LAND_PEAK    = 8'd40;

	localparam logic [31:0] HASH_KX = 32'h8da6b343;
	localparam logic [31:0] HASH_KZ = 32'hd8163841;
	localparam logic [31:0] HASH_KS = 32'hcb1ab31f;
	localparam logic [31:0] HASH_KM = 32'h7feb352d;

	localparam logic [31:0] ROCK_SEED_OFS = 32'd99;

endpackage

// ===== rtl/core/ntc_div_pipe.sv =====
// ----------------------------------------------------------------------------
// ntc_div_pipe: pipelined restoring divider
// One quotient bit per stage, N stages; divisor is held steady by the caller.
// ----------------------------------------------------------------------------
module ntc_div_pipe #(
	parameter int N  = 35,
	parameter int DW = 13
) (
	input  logic          clk,
	input  logic          en,
	input  logic [N-1:0]  dividend,
	input  logic [DW-1:0] divisor,
	output logic [N-1:0]  quotient
);

	logic [DW-1:0] rem_s [N];
	logic [N-1:0]  wrk_s [N];

	for (genvar i = 0; i < N; i++) begin : g_stage
		logic [DW-1:0] rem_in;
		logic [N-1:0]  wrk_in;
		logic [DW:0]   rem_sh;
		logic          take;

		if (i == 0) begin : g_first
			assign rem_in = '0;
			assign wrk_in = dividend;
		end else begin : g_next
			assign rem_in = rem_s[i-1];
			assign wrk_in = wrk_s[i-1];
		end

		assign rem_sh = {rem_in, wrk_in[N-1]};
		assign take   = rem_sh >= {1'b0, divisor};

		always_ff @(posedge clk) begin
			if (en) begin
				rem_s[i] <= take ? DW'(rem_sh - {1'b0, divisor}) : DW'(rem_sh);
				wrk_s[i] <= {wrk_in[N-2:0], take};
			end
		end
	end

	assign quotient = wrk_s[N-1];

endmodule

// ===== rtl/core/ntc_noise.sv =====
// ----------------------------------------------------------------------------
// ntc_noise: one channel of hashed 2D value noise
// Lattice hash of four corners, smoothstep fade, bilinear blend; six stages.
// ----------------------------------------------------------------------------
module ntc_noise #(
	parameter int NFB = 24
) (
	input  logic                       clk,
	input  logic                       en,
	input  logic [ntc_pkg::CRD_W-1:0]  crd_x,
	input  logic [ntc_pkg::CRD_W-1:0]  crd_z,
	input  logic [31:0]                seed_mix,
	output logic [NFB-1:0]             noise
);
	import ntc_pkg::*;

	localparam int MW = 2*NFB + 2;
	localparam int FW = 2*CFRAC;
	localparam int PW = 3*CFRAC + 2;
	localparam logic [NFB:0]     ONE    = (NFB+1)'(1) << NFB;
	localparam logic [CFRAC+1:0] FADE_K = (CFRAC+2)'(3) << CFRAC;

	function automatic logic [NFB-1:0] lerp(input logic [NFB-1:0] p,
		input logic [NFB-1:0] q, input logic [NFB-1:0] u);
		logic [MW-1:0] acc;
		acc = MW'(p) * MW'(ONE - {1'b0, u}) + MW'(q) * MW'(u);
		return acc[NFB +: NFB];
	endfunction

	function automatic logic [NFB-1:0] fade(input logic [FW-1:0] ff,
		input logic [CFRAC-1:0] f);
		logic [PW-1:0] prod;
		prod = PW'(ff) * PW'(FADE_K - {1'b0, f, 1'b0});
		return prod[(3*CFRAC - NFB) +: NFB];
	endfunction

	logic [LAT_IDX_W-1:0] idx_x, idx_z;
	logic [CFRAC-1:0]     frc_x, frc_z;

	assign idx_x = crd_x[CRD_W-1:CFRAC];
	assign idx_z = crd_z[CRD_W-1:CFRAC];
	assign frc_x = crd_x[CFRAC-1:0];
	assign frc_z = crd_z[CFRAC-1:0];

	logic [31:0]      hx_s1, hz_s1;
	logic [FW-1:0]    ffx_s1, ffz_s1;
	logic [CFRAC-1:0] fx_s1, fz_s1;

	always_ff @(posedge clk) begin
		if (en) begin
			hx_s1  <= 32'(idx_x) * HASH_KX + seed_mix;
			hz_s1  <= 32'(idx_z) * HASH_KZ;
			ffx_s1 <= FW'(frc_x) * FW'(frc_x);
			ffz_s1 <= FW'(frc_z) * FW'(frc_z);
			fx_s1  <= frc_x;
			fz_s1  <= frc_z;
		end
	end

	// corners: (x,z) (x+1,z) (x,z+1) (x+1,z+1)
	logic [31:0] hsum [4];

	always_comb begin
		hsum[0] = hx_s1 + hz_s1;
		hsum[1] = hx_s1 + HASH_KX + hz_s1;
		hsum[2] = hx_s1 + hz_s1 + HASH_KZ;
		hsum[3] = hx_s1 + HASH_KX + hz_s1 + HASH_KZ;
	end

	logic [31:0]    pre_s2 [4];
	logic [NFB-1:0] u_s2, v_s2;

	always_ff @(posedge clk) begin
		if (en) begin
			for (int i = 0; i < 4; i++) begin
				pre_s2[i] <= hsum[i] ^ (hsum[i] >> 13);
			end
			u_s2 <= fade(ffx_s1, fx_s1);
			v_s2 <= fade(ffz_s1, fz_s1);
		end
	end

	logic [31:0]    mul_s3 [4];
	logic [NFB-1:0] u_s3, v_s3;

	always_ff @(posedge clk) begin
		if (en) begin
			for (int i = 0; i < 4; i++) begin
				mul_s3[i] <= pre_s2[i] * HASH_KM;
			end
			u_s3 <= u_s2;
			v_s3 <= v_s2;
		end
	end

	logic [31:0] mix [4];

	always_comb begin
		for (int i = 0; i < 4; i++) begin
			mix[i] = mul_s3[i] ^ (mul_s3[i] >> 15);
		end
	end

	logic [NFB-1:0] lat_s4 [4];
	logic [NFB-1:0] u_s4, v_s4;

	always_ff @(posedge clk) begin
		if (en) begin
			for (int i = 0; i < 4; i++) begin
				lat_s4[i] <= mix[i][23 -: NFB];
			end
			u_s4 <= u_s3;
			v_s4 <= v_s3;
		end
	end

	logic [NFB-1:0] top_s5, bot_s5, v_s5, noise_s6;

	always_ff @(posedge clk) begin
		if (en) begin
			top_s5   <= lerp(lat_s4[0], lat_s4[1], u_s4);
			bot_s5   <= lerp(lat_s4[2], lat_s4[3], u_s4);
			v_s5     <= v_s4;
			noise_s6 <= lerp(top_s5, bot_s5, v_s5);
		end
	end

	assign noise = noise_s6;

endmodule

// ===== rtl/core/ntc_blend.sv =====
// ----------------------------------------------------------------------------
// ntc_blend: octave sum, dune height, coastline blend and clamp
// Eight stages; also flags rock from the fourth noise channel.
// ----------------------------------------------------------------------------
module ntc_blend #(
	parameter int NFB = 24
) (
	input  logic                        clk,
	input  logic                        en,
	input  logic [NFB-1:0]              noise_o0,
	input  logic [NFB-1:0]              noise_o1,
	input  logic [NFB-1:0]              noise_o2,
	input  logic [NFB-1:0]              noise_rock,
	input  logic [NFB+6:0]              coast,
	input  logic [ntc_pkg::SPAN_W-1:0]  dune_span,
	input  ntc_pkg::hgt_t               land_peak,
	input  ntc_pkg::hgt_t               height_lim,
	output ntc_pkg::hgt_t               floor_height,
	output logic                        material
);
	import ntc_pkg::*;

	localparam int SW = NFB + 4;
	localparam int RW = NFB + 5;
	localparam int PW = 2*NFB + 9;
	localparam int HW = NFB + SPAN_W;
	localparam int DW = NFB + 8;
	localparam int QW = 2*NFB + 11;
	localparam int TW = 2*NFB + 2;
	localparam int GW = 2*NFB + 3;
	localparam int AW = NFB + 9;

	localparam logic [63:0]   M10   = ((64'd1 << (NFB+8)) + 64'd9) / 64'd10;
	localparam logic [63:0]   M18   = ((64'd1 << (NFB+10)) + 64'd17) / 64'd18;
	localparam logic [NFB:0]  ONE   = (NFB+1)'(1) << NFB;
	localparam logic [DW-1:0] D_OFS = DW'(47) << (NFB-1);
	localparam logic [DW-2:0] D_SAT = (DW-1)'(18) << NFB;

	// octave sum and rock test
	logic [SW-1:0]  sum_s1;
	logic [NFB+6:0] coast_s1;
	logic           mat_s1;

	always_ff @(posedge clk) begin
		if (en) begin
			sum_s1   <= SW'(noise_o0) * SW'(6) + SW'(noise_o1) * SW'(3) + SW'(noise_o2);
			mat_s1   <= (RW'(noise_rock) * RW'(25)) > (RW'(18) << NFB);
			coast_s1 <= coast;
		end
	end

	// divide the sum by ten
	logic [PW-1:0]  sum_prod;
	logic [NFB-1:0] n_s2;
	logic [NFB+6:0] coast_s2;
	logic           mat_s2;

	assign sum_prod = PW'(sum_s1) * PW'(M10);

	always_ff @(posedge clk) begin
		if (en) begin
			n_s2     <= sum_prod[(NFB+8) +: NFB];
			coast_s2 <= coast_s1;
			mat_s2   <= mat_s1;
		end
	end

	// dune height and jittered coast offset (two's complement)
	logic [HW-1:0] dune_prod;
	logic [HGT_W-1:0] hd_s3;
	logic [DW-1:0] d_s3;
	logic          mat_s3;

	assign dune_prod = HW'(n_s2) * HW'(dune_span);

	always_ff @(posedge clk) begin
		if (en) begin
			hd_s3  <= HGT_W'(dune_prod >> NFB) + HGT_W'(1);
			d_s3   <= DW'(coast_s2) + DW'(n_s2) * DW'(5) - D_OFS;
			mat_s3 <= mat_s2;
		end
	end

	// ramp position over the coast band
	logic [QW-1:0]    ramp_prod;
	logic [NFB:0]     t_s4;
	logic [HGT_W-1:0] hd_s4;
	logic             mat_s4;

	assign ramp_prod = QW'(d_s3[NFB+4:0]) * QW'(M18);

	always_ff @(posedge clk) begin
		if (en) begin
			if (d_s3[DW-1] || d_s3 == '0) begin
				t_s4 <= '0;
			end else if (d_s3[DW-2:0] >= D_SAT) begin
				t_s4 <= ONE;
			end else begin
				t_s4 <= ramp_prod[(NFB+10) +: (NFB+1)];
			end
			hd_s4  <= hd_s3;
			mat_s4 <= mat_s3;
		end
	end

	logic [TW-1:0]    tt_prod;
	logic [NFB:0]     t2_s5;
	logic [NFB+1:0]   g_s5;
	logic [HGT_W-1:0] hd_s5;
	logic             mat_s5;

	assign tt_prod = TW'(t_s4) * TW'(t_s4);

	always_ff @(posedge clk) begin
		if (en) begin
			t2_s5  <= tt_prod[NFB +: (NFB+1)];
			g_s5   <= ((NFB+2)'(3) << NFB) - {t_s4, 1'b0};
			hd_s5  <= hd_s4;
			mat_s5 <= mat_s4;
		end
	end

	logic [GW-1:0]    w_prod;
	logic [NFB:0]     w_s6;
	logic [HGT_W-1:0] hd_s6;
	logic             mat_s6;

	assign w_prod = GW'(t2_s5) * GW'(g_s5);

	always_ff @(posedge clk) begin
		if (en) begin
			w_s6   <= w_prod[NFB +: (NFB+1)];
			hd_s6  <= hd_s5;
			mat_s6 <= mat_s5;
		end
	end

	// blend toward the land peak, round half up
	logic [AW-1:0]    acc;
	logic [HGT_W-1:0] h_s7, fh_s8;
	logic             mat_s7, mat_s8;

	assign acc = AW'(hd_s6) * AW'(ONE - w_s6) + AW'(land_peak) * AW'(w_s6)
		+ (AW'(ONE) >> 1);

	always_ff @(posedge clk) begin
		if (en) begin
			h_s7   <= acc[NFB +: HGT_W];
			mat_s7 <= mat_s6;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			if (h_s7 == '0) begin
				fh_s8 <= HGT_W'(1);
			end else if (h_s7 > height_lim - HGT_W'(1)) begin
				fh_s8 <= height_lim - HGT_W'(1);
			end else begin
				fh_s8 <= h_s7;
			end
			mat_s8 <= mat_s7;
		end
	end

	assign floor_height = fh_s8;
	assign material     = mat_s8;

endmodule

// ===== rtl/core/noise_terrain_column_gen.sv =====
// ----------------------------------------------------------------------------
// noise_terrain_column_gen: floor height and material of one grid column
// Three-octave value noise dunes blended toward a land peak across a
// diagonal coastline, plus a rock/sand noise channel.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel (in_valid / in_stall): one column (column_x, column_z) per
//   transfer. Output channel (out_valid / out_stall): one floor_height and
//   material per column, in order of arrival.
//   Throughput: one column per cycle while out_stall does not hold the
//   pipeline, with no gaps between columns. The bit-serial dividers that
//   scale the coordinates set most of the latency: one quotient bit per
//   stage.
//   Configuration (cfg_valid / cfg_ready, cfg_index, cfg_data): cfg_ready is
//   always high; write only while no column is in flight. Indexes above the
//   register list are dropped.
//   Reset: registers return to extent 256, height limit 64, seed 0, peak 40;
//   the pipeline empties.
//   Stall: while a result waits under out_stall, every stage holds and
//   in_stall rises in the same cycle; nothing is dropped or repeated.
// ----------------------------------------------------------------------------
module noise_terrain_column_gen #(
	parameter int MAX_EXTENT      = 4096,
	parameter int NOISE_FRAC_BITS = 24
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_valid,
	output logic               in_stall,
	input  ntc_pkg::col_t      column_x,
	input  ntc_pkg::col_t      column_z,
	output logic               out_valid,
	input  logic               out_stall,
	output ntc_pkg::hgt_t      floor_height,
	output logic               material,
	input  logic               cfg_valid,
	output logic               cfg_ready,
	input  ntc_pkg::cfg_idx_t  cfg_index,
	input  ntc_pkg::cfg_data_t cfg_data
);
	import ntc_pkg::*;

	localparam int NFB   = NOISE_FRAC_BITS;
	localparam int DIVW  = (NFB + 18 > 35) ? NFB + 18 : 35;
	localparam int CST_W = NFB + 7;
	localparam int LAT   = 1 + DIVW + NOISE_LAT + BLEND_LAT;
	// past this coast value the blend is fully on the land side
	localparam logic [DIVW-1:0] COAST_CAP = DIVW'(1) << (NFB + 6);

	// ------------------------------------------------------------------
	// configuration registers
	// ------------------------------------------------------------------
	logic [EXT_W-1:0]  grid_extent_q;
	logic [HGT_W-1:0]  height_limit_q;
	logic [SEED_W-1:0] noise_seed_q;
	logic [HGT_W-1:0]  land_peak_q;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			grid_extent_q  <= RST_GRID_EXTENT;
			height_limit_q <= RST_HEIGHT_LIMIT;
			noise_seed_q   <= RST_NOISE_SEED;
			land_peak_q    <= RST_LAND_PEAK;
		end else if (cfg_valid && cfg_ready) begin
			unique case (cfg_index)
				CFG_GRID_EXTENT:  grid_extent_q  <= cfg_data[EXT_W-1:0];
				CFG_HEIGHT_LIMIT: height_limit_q <= cfg_data[HGT_W-1:0];
				CFG_NOISE_SEED:   noise_seed_q   <= cfg_data[SEED_W-1:0];
				CFG_LAND_PEAK:    land_peak_q    <= cfg_data[HGT_W-1:0];
				default: ;
			endcase
		end
	end

	// ------------------------------------------------------------------
	// values derived from configuration; they settle in the cycle after a write,
	// well before any column reaches the stages that read them
	// ------------------------------------------------------------------
	logic [EXT_W-1:0]  ext_c;
	logic [HGT_W-1:0]  hlim_c, third_c;
	logic [SPAN_W-1:0] span_c;

	always_comb begin
		if (grid_extent_q < EXT_W'(2)) begin
			ext_c = EXT_W'(2);
		end else if (32'(grid_extent_q) > MAX_EXTENT) begin
			ext_c = EXT_W'(MAX_EXTENT);
		end else begin
			ext_c = grid_extent_q;
		end
		hlim_c  = (height_limit_q < HGT_W'(3)) ? HGT_W'(3) : height_limit_q;
		third_c = HGT_W'((16'(hlim_c) * 16'(DIV3_MUL)) >> DIV3_SHIFT);
		span_c  = (third_c < HGT_W'(2)) ? SPAN_W'(1) : SPAN_W'(third_c - HGT_W'(1));
	end

	logic [EXT_W-1:0]  ext_q, ext_m1_q;
	logic [HGT_W-1:0]  hlim_q;
	logic [SPAN_W-1:0] span_q;
	logic [31:0]       seed_mix_q [4];

	always_ff @(posedge clk) begin
		ext_q         <= ext_c;
		ext_m1_q      <= ext_c - EXT_W'(1);
		hlim_q        <= hlim_c;
		span_q        <= span_c;
		seed_mix_q[0] <= noise_seed_q * HASH_KS;
		seed_mix_q[1] <= (noise_seed_q + 32'd1) * HASH_KS;
		seed_mix_q[2] <= (noise_seed_q + 32'd2) * HASH_KS;
		seed_mix_q[3] <= (noise_seed_q + ROCK_SEED_OFS) * HASH_KS;
	end

	// ------------------------------------------------------------------
	// pipeline control: one enable for all stages, valid bits alongside
	// ------------------------------------------------------------------
	logic           en;
	logic [LAT-1:0] vld_s;

	assign en        = !(out_valid && out_stall);
	assign in_stall  = !en;
	assign out_valid = vld_s[LAT-1];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s <= '0;
		end else if (en) begin
			vld_s <= {vld_s[LAT-2:0], in_valid};
		end
	end

	// ------------------------------------------------------------------
	// input stage: capture the column, form the coastline numerator
	// ------------------------------------------------------------------
	col_t                   col_x_s1, col_z_s1;
	logic [COAST_NUM_W-1:0] coast_num_s1;

	always_ff @(posedge clk) begin
		if (en) begin
			col_x_s1     <= column_x;
			col_z_s1     <= column_z;
			coast_num_s1 <= COAST_NUM_W'(COAST_NUM_W'(column_x) + COAST_NUM_W'(column_z))
				* COAST_NUM_W'(COAST_GAIN);
		end
	end

	// ------------------------------------------------------------------
	// scale by the extent: x*2^23/E, z*2^23/E, 25(x+z)*2^F/(E-1)
	// ------------------------------------------------------------------
	logic [DIVW-1:0] quo_x, quo_z, quo_c;

	ntc_div_pipe #(.N(DIVW), .DW(EXT_W)) u_div_x (
		.clk      (clk),
		.en       (en),
		.dividend (DIVW'({col_x_s1, {FX_SCALE{1'b0}}})),
		.divisor  (ext_q),
		.quotient (quo_x)
	);

	ntc_div_pipe #(.N(DIVW), .DW(EXT_W)) u_div_z (
		.clk      (clk),
		.en       (en),
		.dividend (DIVW'({col_z_s1, {FX_SCALE{1'b0}}})),
		.divisor  (ext_q),
		.quotient (quo_z)
	);

	ntc_div_pipe #(.N(DIVW), .DW(EXT_W)) u_div_coast (
		.clk      (clk),
		.en       (en),
		.dividend (DIVW'(coast_num_s1) << NFB),
		.divisor  (ext_m1_q),
		.quotient (quo_c)
	);

	// ------------------------------------------------------------------
	// octave coordinates (Q.20): f, 2f, 4f and 1.5f for the rock channel
	// ------------------------------------------------------------------
	logic [CRD_W-1:0] crd_x0, crd_x1, crd_x2, crd_xr;
	logic [CRD_W-1:0] crd_z0, crd_z1, crd_z2, crd_zr;

	always_comb begin
		crd_x0 = CRD_W'(quo_x[FX_W-1:0]);
		crd_z0 = CRD_W'(quo_z[FX_W-1:0]);
		crd_x1 = crd_x0 << 1;
		crd_z1 = crd_z0 << 1;
		crd_x2 = crd_x0 << 2;
		crd_z2 = crd_z0 << 2;
		crd_xr = crd_x0 + (crd_x0 >> 1);
		crd_zr = crd_z0 + (crd_z0 >> 1);
	end

	logic [NFB-1:0] noise_o0, noise_o1, noise_o2, noise_rock;

	ntc_noise #(.NFB(NFB)) u_noise_o0 (
		.clk(clk), .en(en), .crd_x(crd_x0), .crd_z(crd_z0),
		.seed_mix(seed_mix_q[0]), .noise(noise_o0)
	);

	ntc_noise #(.NFB(NFB)) u_noise_o1 (
		.clk(clk), .en(en), .crd_x(crd_x1), .crd_z(crd_z1),
		.seed_mix(seed_mix_q[1]), .noise(noise_o1)
	);

	ntc_noise #(.NFB(NFB)) u_noise_o2 (
		.clk(clk), .en(en), .crd_x(crd_x2), .crd_z(crd_z2),
		.seed_mix(seed_mix_q[2]), .noise(noise_o2)
	);

	ntc_noise #(.NFB(NFB)) u_noise_rock (
		.clk(clk), .en(en), .crd_x(crd_xr), .crd_z(crd_zr),
		.seed_mix(seed_mix_q[3]), .noise(noise_rock)
	);

	// ------------------------------------------------------------------
	// coastline coordinate: saturate, then hold it beside the noise units
	// ------------------------------------------------------------------
	logic [CST_W-1:0] coast_sat;
	logic [CST_W-1:0] coast_s [NOISE_LAT];

	assign coast_sat = (quo_c >= COAST_CAP) ? CST_W'(COAST_CAP) : CST_W'(quo_c);

	always_ff @(posedge clk) begin
		if (en) begin
			coast_s[0] <= coast_sat;
			for (int i = 1; i < NOISE_LAT; i++) begin
				coast_s[i] <= coast_s[i-1];
			end
		end
	end

	// ------------------------------------------------------------------
	// octave sum, blend, clamp; its last stage is the output register
	// ------------------------------------------------------------------
	ntc_blend #(.NFB(NFB)) u_blend (
		.clk          (clk),
		.en           (en),
		.noise_o0     (noise_o0),
		.noise_o1     (noise_o1),
		.noise_o2     (noise_o2),
		.noise_rock   (noise_rock),
		.coast        (coast_s[NOISE_LAT-1]),
		.dune_span    (span_q),
		.land_peak    (land_peak_q),
		.height_lim   (hlim_q),
		.floor_height (floor_height),
		.material     (material)
	);

endmodule
